/* sv/slex_pkg.sv */
// Package for the source lexer: token kinds, table sizes, keyword table.
// No dependencies.
package slex_pkg;
    localparam int SYMBOLS    = 256;
    localparam int NAME_CHARS = 8;
    localparam int SYM_AW     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CNT_W      = $clog2(SYMBOLS + 1);

    localparam logic [2:0] K_KEYWORD = 3'd0;
    localparam logic [2:0] K_IDENT   = 3'd1;
    localparam logic [2:0] K_CONST   = 3'd2;
    localparam logic [2:0] K_STRING  = 3'd3;
    localparam logic [2:0] K_CHAR    = 3'd4;
    localparam logic [2:0] K_OPER    = 3'd5;
    localparam logic [2:0] K_SPECIAL = 3'd6;
    localparam logic [2:0] K_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [8:0]  token_value;
        logic [63:0] token_text;
        logic [7:0]  token_length;
        logic [15:0] line_no;
        logic        new_symbol;
        logic        table_full;
        logic        name_truncated;
        logic        unterminated;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
    } req_t;

    // Keyword text packed first char low; length given by kw_len
    function automatic logic [63:0] kw_text(input logic [3:0] i);
        case (i)
            4'd0:  kw_text = 64'h0000_0000_0074_6e69;
            4'd1:  kw_text = 64'h0000_0074_616f_6c66;
            4'd2:  kw_text = 64'h0000_0000_7261_6863;
            4'd3:  kw_text = 64'h0000_0000_0000_6669;
            4'd4:  kw_text = 64'h0000_0000_6573_6c65;
            4'd5:  kw_text = 64'h0000_0065_6c69_6877;
            4'd6:  kw_text = 64'h0000_0000_0072_6f66;
            4'd7:  kw_text = 64'h0000_6e72_7574_6572;
            4'd8:  kw_text = 64'h0000_6674_6e69_7270;
            4'd9:  kw_text = 64'h0000_0066_6e61_6373;
            4'd10: kw_text = 64'h0000_0000_6e69_616d;
            4'd11: kw_text = 64'h0000_676e_6972_7473;
            default: kw_text = 64'h0;
        endcase
    endfunction

    function automatic logic [7:0] kw_len(input logic [3:0] i);
        case (i)
            4'd0, 4'd6:                kw_len = 8'd3;
            4'd1, 4'd5, 4'd9:          kw_len = 8'd5;
            4'd2, 4'd4, 4'd10:         kw_len = 8'd4;
            4'd3:                      kw_len = 8'd2;
            4'd7, 4'd8, 4'd11:         kw_len = 8'd6;
            default:                   kw_len = 8'd0;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= 8'h30 && c <= 8'h39;
    endfunction
    function automatic logic is_space(input logic [7:0] c);
        is_space = c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_op(input logic [7:0] c);
        is_op = c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25 ||
                c == 8'h3d || c == 8'h3e || c == 8'h3c || c == 8'h26 || c == 8'h7c ||
                c == 8'h21;
    endfunction
    function automatic logic is_special(input logic [7:0] c);
        is_special = c == 8'h28 || c == 8'h29 || c == 8'h7b || c == 8'h7d ||
                     c == 8'h5b || c == 8'h5d || c == 8'h3b || c == 8'h2c || c == 8'h2e;
    endfunction
endpackage

/* sv/slex_if.sv */
// Valid/ready channel interface carrying one request or token descriptor.
// Depends on nothing; payload type is a parameter of the interface.
interface slex_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/source_lexer_with_symbol_table.sv */
// Source lexer top level: tokenizer state machine with a symbol table memory.
// Depends on slex_pkg and slex_if.
//
// One request (a source byte or end of input) is taken per pass. A request that
// gives no token goes from S_EXEC straight back to S_IDLE. One that gives tokens
// goes on through S_EMIT to S_WAIT and waits there until the output drains.
// A request that ends an identifier walks the symbol name memory one entry per
// cycle in S_SRCH before S_EMIT; the walk is not held by output stalls. A request
// gives up to two tokens, delivered through an output register;
// the second token is held in a skid register.
// The table needs no clearing pass: entries at or above the fill count are
// never compared.
module source_lexer_with_symbol_table (
    input  logic  clk,
    input  logic  rst_n,
    slex_if.sink   req,
    slex_if.source tok
);
    import slex_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SRCH = 5'b00100,
        S_EMIT = 5'b01000,
        S_WAIT = 5'b10000
    } st_t;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_STR, M_CHR, M_OPER, M_SLASH, M_LCOM, M_BCOM, M_BSTAR
    } lm_t;

    // Symbol name memory, registered read
    logic [63:0] names_mem [SYMBOLS];
    logic [15:0] lines_mem [SYMBOLS];
    logic [63:0] rd_reg;
    logic [SYM_AW-1:0] raddr;
    logic we;
    logic [SYM_AW-1:0] waddr;
    logic [63:0] wname;
    logic [15:0] wline;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            names_mem[waddr] <= wname;
            lines_mem[waddr] <= wline;
        end
        rd_reg <= names_mem[raddr];
    end

    st_t st_reg, st_next;
    lm_t mode_reg, mode_next;
    logic [63:0] ptext_reg, ptext_next;
    logic [7:0]  plen_reg, plen_next;
    logic [15:0] line_reg, line_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic rvld_reg, rvld_next;
    logic [7:0] ch_reg, ch_next;
    logic eoi_reg, eoi_next;
    logic [63:0] key_reg, key_next;
    logic [63:0] wtext_reg, wtext_next;
    logic [7:0]  wlen_reg, wlen_next;
    tok_t o_reg, o_next, s_reg, s_next;
    logic ov_reg, ov_next, sv_reg, sv_next;

    localparam logic [63:0] KEY_MASK = (NAME_CHARS >= 8) ? {64{1'b1}} :
        ((64'd1 << (8 * NAME_CHARS)) - 64'd1);

    assign req.ready = (st_reg == S_IDLE) && !ov_reg;
    assign tok.valid = ov_reg;
    assign tok.data  = o_reg;
    assign raddr = idx_next[SYM_AW-1:0];

    function automatic tok_t mk(input logic [2:0] k, input logic [8:0] v,
                                input logic [63:0] t, input logic [7:0] l,
                                input logic [15:0] ln, input logic u);
        tok_t r;
        r = '0;
        r.token_kind = k; r.token_value = v; r.token_text = t;
        r.token_length = l; r.line_no = ln; r.unterminated = u;
        mk = r;
    endfunction

    always_comb
    begin
        tok_t t0, t1;
        logic n0, n1;
        logic [7:0] c;
        logic [63:0] at;
        logic [7:0] al;
        logic need_word;
        logic [15:0] linc;
        logic idle_c;
        logic kw_hit;
        logic [3:0] kw_i;
        logic [8:0] id;
        st_next = st_reg; mode_next = mode_reg; ptext_next = ptext_reg;
        plen_next = plen_reg; line_next = line_reg; cnt_next = cnt_reg;
        idx_next = idx_reg; rvld_next = 1'b0; ch_next = ch_reg; eoi_next = eoi_reg;
        key_next = key_reg; wtext_next = wtext_reg; wlen_next = wlen_reg;
        o_next = o_reg; s_next = s_reg; ov_next = ov_reg; sv_next = sv_reg;
        we = 1'b0; waddr = cnt_reg[SYM_AW-1:0]; wname = key_reg; wline = line_reg;
        t0 = '0; t1 = '0; n0 = 1'b0; n1 = 1'b0; need_word = 1'b0; idle_c = 1'b0;
        c = ch_reg; kw_hit = 1'b0; kw_i = 4'd0; id = 9'd0;
        linc = (line_reg != 16'hffff) ? line_reg + 16'd1 : line_reg;
        at = ptext_reg;
        if (plen_reg < 8'd8) at = ptext_reg | ({56'd0, c} << {plen_reg[2:0], 3'b000});
        al = (plen_reg != 8'hff) ? plen_reg + 8'd1 : plen_reg;

        // Drain output register, then skid
        if (ov_reg && tok.ready)
        begin
            ov_next = sv_reg; o_next = s_reg; sv_next = 1'b0;
        end

        case (st_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    ch_next = req.data.char_code;
                    eoi_next = req.data.req_type;
                    st_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Apply one byte, or end of input, to the lexer mode
                if (eoi_reg)
                begin
                    case (mode_reg)
                        M_WORD: need_word = 1'b1;
                        M_NUM: begin t0 = mk(K_CONST, 9'd0, ptext_reg, plen_reg, line_reg, 1'b0); n0 = 1'b1; end
                        M_STR: begin t0 = mk(K_STRING, 9'd0, ptext_reg, plen_reg, line_reg, 1'b1); n0 = 1'b1; end
                        M_CHR: begin t0 = mk(K_CHAR, 9'd0, ptext_reg, plen_reg, line_reg, 1'b1); n0 = 1'b1; end
                        M_OPER, M_SLASH: begin t0 = mk(K_OPER, 9'd0, ptext_reg, plen_reg, line_reg, 1'b0); n0 = 1'b1; end
                        M_BCOM, M_BSTAR: begin t0 = mk(K_UNKNOWN, 9'd0, 64'd0, 8'd0, line_reg, 1'b1); n0 = 1'b1; end
                        default: ;
                    endcase
                    if (!need_word)
                    begin
                        mode_next = M_IDLE; ptext_next = '0; plen_next = '0;
                        line_next = 16'd1;
                    end
                end
                else
                begin
                    case (mode_reg)
                        M_WORD:
                            if (is_alpha(c) || is_digit(c) || c == 8'h5f)
                            begin ptext_next = at; plen_next = al; end
                            else need_word = 1'b1;
                        M_NUM:
                            if (is_digit(c)) begin ptext_next = at; plen_next = al; end
                            else begin t0 = mk(K_CONST, 9'd0, ptext_reg, plen_reg, line_reg, 1'b0); n0 = 1'b1; idle_c = 1'b1; end
                        M_STR, M_CHR:
                        begin
                            ptext_next = at; plen_next = al;
                            if (c == 8'h0a) line_next = linc;
                            if ((mode_reg == M_STR && c == 8'h22) || (mode_reg == M_CHR && c == 8'h27))
                            begin
                                t0 = mk((mode_reg == M_STR) ? K_STRING : K_CHAR, 9'd0, at, al,
                                        (c == 8'h0a) ? linc : line_reg, 1'b0);
                                n0 = 1'b1; mode_next = M_IDLE; ptext_next = '0; plen_next = '0;
                            end
                        end
                        M_OPER:
                            if (is_op(c)) begin ptext_next = at; plen_next = al; end
                            else begin t0 = mk(K_OPER, 9'd0, ptext_reg, plen_reg, line_reg, 1'b0); n0 = 1'b1; idle_c = 1'b1; end
                        M_SLASH:
                            if (c == 8'h2f || c == 8'h2a)
                            begin
                                ptext_next = '0; plen_next = '0;
                                mode_next = (c == 8'h2f) ? M_LCOM : M_BCOM;
                            end
                            else if (is_op(c)) begin ptext_next = at; plen_next = al; mode_next = M_OPER; end
                            else begin t0 = mk(K_OPER, 9'd0, ptext_reg, plen_reg, line_reg, 1'b0); n0 = 1'b1; idle_c = 1'b1; end
                        M_LCOM:
                            if (c == 8'h0a) begin line_next = linc; mode_next = M_IDLE; end
                        M_BCOM:
                            if (c == 8'h2a) mode_next = M_BSTAR;
                            else if (c == 8'h0a) line_next = linc;
                        M_BSTAR:
                            if (c == 8'h2f) mode_next = M_IDLE;
                            else if (c != 8'h2a)
                            begin
                                mode_next = M_BCOM;
                                if (c == 8'h0a) line_next = linc;
                            end
                        default: idle_c = 1'b1;
                    endcase
                end
                if (need_word)
                begin
                    // Keyword check, else start the table walk
                    for (int i = 0; i < 12; i++)
                        if (!kw_hit && kw_len(4'(i)) == plen_reg && kw_text(4'(i)) == ptext_reg)
                        begin
                            kw_hit = 1'b1; kw_i = 4'(i);
                        end
                    if (kw_hit)
                    begin
                        t0 = mk(K_KEYWORD, {5'd0, kw_i}, ptext_reg, plen_reg, line_reg, 1'b0);
                        n0 = 1'b1;
                        if (eoi_reg) line_next = 16'd1; else idle_c = 1'b1;
                        mode_next = M_IDLE; ptext_next = '0; plen_next = '0;
                    end
                    else
                    begin
                        key_next = ptext_reg & KEY_MASK;
                        wtext_next = ptext_reg; wlen_next = plen_reg;
                        idx_next = '0; rvld_next = (cnt_reg != '0);
                        mode_next = M_IDLE; ptext_next = '0; plen_next = '0;
                        st_next = S_SRCH;
                    end
                end
                if (idle_c)
                begin
                    mode_next = M_IDLE;
                    if (is_space(c)) begin if (c == 8'h0a) line_next = linc; end
                    else if (is_alpha(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_WORD; end
                    else if (is_digit(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_NUM; end
                    else if (c == 8'h22) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_STR; end
                    else if (c == 8'h27) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_CHR; end
                    else if (c == 8'h2f) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_SLASH; end
                    else if (is_op(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_OPER; end
                    else begin
                        t1 = mk(is_special(c) ? K_SPECIAL : K_UNKNOWN, 9'd0, {56'd0, c}, 8'd1,
                                line_reg, 1'b0);
                        n1 = 1'b1;
                    end
                end
                if (st_next != S_SRCH)
                    st_next = (n0 || n1) ? S_EMIT : S_IDLE;
            end
            S_SRCH:
            begin
                // Compare one stored name per cycle
                if (rvld_reg && rd_reg == key_reg)
                begin
                    id = 9'(idx_reg + 1'b1);
                    t0 = mk(K_IDENT, id, wtext_reg, wlen_reg, line_reg, 1'b0);
                    n0 = 1'b1;
                end
                else if (rvld_reg && (idx_reg + 1'b1) < cnt_reg)
                begin
                    idx_next = idx_reg + 1'b1; rvld_next = 1'b1;
                end
                else
                begin
                    t0 = mk(K_IDENT, 9'd0, wtext_reg, wlen_reg, line_reg, 1'b0);
                    if (cnt_reg < CNT_W'(SYMBOLS))
                    begin
                        we = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                        t0.token_value = 9'(cnt_reg + 1'b1);
                        t0.new_symbol = 1'b1;
                    end
                    else t0.table_full = 1'b1;
                    n0 = 1'b1;
                end
                if (n0)
                begin
                    t0.name_truncated = wlen_reg > 8'(NAME_CHARS);
                    if (eoi_reg) line_next = 16'd1;
                    else
                    begin
                        c = ch_reg;
                        if (is_space(c)) begin if (c == 8'h0a) line_next = linc; end
                        else if (is_alpha(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_WORD; end
                        else if (is_digit(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_NUM; end
                        else if (c == 8'h22) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_STR; end
                        else if (c == 8'h27) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_CHR; end
                        else if (c == 8'h2f) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_SLASH; end
                        else if (is_op(c)) begin ptext_next = {56'd0, c}; plen_next = 8'd1; mode_next = M_OPER; end
                        else begin
                            t1 = mk(is_special(c) ? K_SPECIAL : K_UNKNOWN, 9'd0, {56'd0, c},
                                    8'd1, line_reg, 1'b0);
                            n1 = 1'b1;
                        end
                    end
                    st_next = S_EMIT;
                end
            end
            S_EMIT: st_next = S_WAIT;
            S_WAIT: if (!ov_reg) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase

        // Load produced tokens into output register and skid
        if (n0 || n1)
        begin
            if (n0 && n1) begin t1.last = 1'b1; o_next = t0; s_next = t1; sv_next = 1'b1; end
            else if (n0) begin t0.last = 1'b1; o_next = t0; end
            else begin t1.last = 1'b1; o_next = t1; end
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; mode_reg <= M_IDLE; ptext_reg <= '0; plen_reg <= '0;
            line_reg <= 16'd1; cnt_reg <= '0; idx_reg <= '0; rvld_reg <= 1'b0;
            ov_reg <= 1'b0; sv_reg <= 1'b0; eoi_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; mode_reg <= mode_next; ptext_reg <= ptext_next;
            plen_reg <= plen_next; line_reg <= line_next; cnt_reg <= cnt_next;
            idx_reg <= idx_next; rvld_reg <= rvld_next; ov_reg <= ov_next;
            sv_reg <= sv_next; eoi_reg <= eoi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next; key_reg <= key_next; wtext_reg <= wtext_next;
        wlen_reg <= wlen_next; o_reg <= o_next; s_reg <= s_next;
    end

    // Tokens are only produced from a busy state, never while waiting for a request
    a_skid: assert property (@(posedge clk) disable iff (!rst_n) sv_reg |-> ov_reg)
        else $error("skid valid without output valid");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SYMBOLS)) else $error("symbol count overflow");
    a_we: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("write without count");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_SRCH) |-> !req.ready) else $error("ready during search");
endmodule
